/* hdl/aabb_query_distance_2d_top_assert.svh */
// Assertion macros for the box gap distance block.
// Uses the clk and arst_n names of the including module; no other dependencies.
`ifndef AABB_QUERY_DISTANCE_2D_TOP_ASSERT_SVH
`define AABB_QUERY_DISTANCE_2D_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define AQD_ASSERT_IMPLIES(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aabbqd: same-cycle check failed");
// next-cycle implication, checked out of reset
`define AQD_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("aabbqd: next-cycle check failed");
`else
`define AQD_ASSERT_IMPLIES(name, ante, cons)
`define AQD_ASSERT_NEXT(name, ante, cons)
`endif
`endif

/* hdl/aabbqd_pkg.sv */
// Shared types and constants for the box gap distance block.
// No dependencies.
`timescale 1ns / 1ps

package aabbqd_pkg;

	localparam int DATA_W     = 32;
	localparam int HALF_W     = 31;
	localparam int TOL_W      = 16;
	localparam int GAP_W      = 33;
	localparam int DIST_W     = 34;
	localparam int CFG_ADDR_W = 5;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_BOX_CENTER_X    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_BOX_CENTER_Y    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_BOX_HALF_LENGTH = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_BOX_HALF_WIDTH  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TOLERANCE       = 3'd4;

	typedef struct packed {
		logic signed [DATA_W-1:0] query_x;
		logic signed [DATA_W-1:0] query_y;
		logic        [HALF_W-1:0] query_half_length;
		logic        [HALF_W-1:0] query_half_width;
	} query_t;

	typedef struct packed {
		logic [GAP_W-1:0] gap_distance;
		logic             overlap;
		logic             center_inside;
		logic             center_on_boundary;
	} result_t;

	// travels beside the root through the square root pipeline
	typedef struct packed {
		logic             use_root;
		logic [GAP_W-1:0] direct_gap;
		logic             overlap;
		logic             center_inside;
		logic             center_on_boundary;
	} side_t;

endpackage

/* hdl/aabbqd_isqrt.sv */
// Pipelined floor square root, one result bit per stage, with side data.
// Depends on aabbqd_pkg.
`timescale 1ns / 1ps

module aabbqd_isqrt import aabbqd_pkg::*; #(
	parameter int RW = 33
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [2*RW-1:0] rad,
	input  side_t           in_side,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [RW-1:0]   root,
	output side_t           out_side
);

	logic            vld_s  [0:RW-1];
	logic [RW-1:0]   root_s [0:RW-1];
	side_t           side_s [0:RW-1];
	logic [2*RW-1:0] rad_s  [0:RW-2];
	logic [RW:0]     rem_s  [0:RW-2];
	logic            rdy    [0:RW];

	assign rdy[RW] = out_ready;

	genvar k;
	for (k = 0; k < RW; k++) begin : g_stage
		logic [2*RW-1:0] prev_rad;
		logic [RW:0]     prev_rem;
		logic [RW-1:0]   prev_root;
		logic            prev_vld;
		side_t           prev_side;
		logic [RW+2:0]   cur;
		logic [RW+2:0]   trial;
		logic [RW+2:0]   diff;
		logic            take;

		if (k == 0) begin : g_first
			assign prev_rad  = rad;
			assign prev_rem  = '0;
			assign prev_root = '0;
			assign prev_vld  = in_valid;
			assign prev_side = in_side;
		end else begin : g_next
			assign prev_rad  = rad_s[k-1];
			assign prev_rem  = rem_s[k-1];
			assign prev_root = root_s[k-1];
			assign prev_vld  = vld_s[k-1];
			assign prev_side = side_s[k-1];
		end

		// bring down the next two radicand bits and try root*4+1
		assign cur   = {prev_rem, prev_rad[2*RW-1 -: 2]};
		assign trial = {1'b0, prev_root, 2'b01};
		assign take  = (cur >= trial);
		assign diff  = cur - trial;

		// advance when empty or when the next stage moves
		assign rdy[k] = !vld_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= prev_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && prev_vld) begin
				root_s[k] <= {prev_root[RW-2:0], take};
				side_s[k] <= prev_side;
			end
		end

		if (k < RW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (rdy[k] && prev_vld) begin
					rad_s[k] <= {prev_rad[2*RW-3:0], 2'b00};
					rem_s[k] <= take ? diff[RW:0] : cur[RW:0];
				end
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[RW-1];
	assign root      = root_s[RW-1];
	assign out_side  = side_s[RW-1];

endmodule

/* hdl/aabb_query_distance_2d_top.sv */
// Top level of the 2-D box gap distance block: front stages, config port, root.
// Depends on aabbqd_pkg, aabbqd_isqrt and aabb_query_distance_2d_top_assert.svh.
//
//  channel   direction  handshake             word
//  query     in         query_valid/stall     query_t: center and half extents
//  result    out        result_valid/stall    result_t: gap, overlap, center tests
//  config    in         psel/penable/pready   32-bit register write and read
//
// One word enters per clock while query_stall is low; the gap comes from the
// square root pipeline, which settles one root bit per stage.
// Reset clears all valid bits and the configuration registers; there is no
// clearing pass. A stalled result holds in the last root stage while empty
// stages upstream keep taking words, so input stalls only once the pipe is full.
`timescale 1ns / 1ps

`include "aabb_query_distance_2d_top_assert.svh"

module aabb_query_distance_2d_top import aabbqd_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// query channel
	input  logic                  query_valid,
	output logic                  query_stall,
	input  query_t                query,
	// result channel
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]     pwdata,
	output logic [DATA_W-1:0]     prdata,
	output logic                  pready
);

	localparam int CW = COORD_WIDTH;
	localparam int RW = CW + 1;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [DATA_W-1:0]    box_center_x_q;
	logic [DATA_W-1:0]    box_center_y_q;
	logic [HALF_W-1:0]    box_half_length_q;
	logic [HALF_W-1:0]    box_half_width_q;
	logic [TOL_W-1:0]     tolerance_q;
	logic                 cfg_wr;
	logic [REG_IDX_W-1:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[CFG_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_center_x_q    <= '0;
			box_center_y_q    <= '0;
			box_half_length_q <= '0;
			box_half_width_q  <= '0;
			tolerance_q       <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_BOX_CENTER_X:    box_center_x_q    <= pwdata;
				REG_BOX_CENTER_Y:    box_center_y_q    <= pwdata;
				REG_BOX_HALF_LENGTH: box_half_length_q <= pwdata[HALF_W-1:0];
				REG_BOX_HALF_WIDTH:  box_half_width_q  <= pwdata[HALF_W-1:0];
				REG_TOLERANCE:       tolerance_q       <= pwdata[TOL_W-1:0];
				default: ; // drop writes past the register list
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_BOX_CENTER_X:    prdata = box_center_x_q;
			REG_BOX_CENTER_Y:    prdata = box_center_y_q;
			REG_BOX_HALF_LENGTH: prdata = DATA_W'(box_half_length_q);
			REG_BOX_HALF_WIDTH:  prdata = DATA_W'(box_half_width_q);
			REG_TOLERANCE:       prdata = DATA_W'(tolerance_q);
			default:             prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Pipeline control: a stage takes a word when empty or when it drains
	// ------------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic sq_in_ready;

	assign rdy5 = !vld_s5 || sq_in_ready;
	assign rdy4 = !vld_s4 || rdy5;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;

	assign query_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= query_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: center differences on COORD_WIDTH-bit two's complement values
	// ------------------------------------------------------------------
	logic [CW:0]       qx_ext, qy_ext, cx_ext, cy_ext;
	logic [CW:0]       diff_x_s1, diff_y_s1;
	logic [HALF_W-1:0] qhl_s1, qhw_s1;

	assign qx_ext = {query.query_x[CW-1], query.query_x[CW-1:0]};
	assign qy_ext = {query.query_y[CW-1], query.query_y[CW-1:0]};
	assign cx_ext = {box_center_x_q[CW-1], box_center_x_q[CW-1:0]};
	assign cy_ext = {box_center_y_q[CW-1], box_center_y_q[CW-1:0]};

	always_ff @(posedge clk) begin
		if (rdy1 && query_valid) begin
			diff_x_s1 <= qx_ext - cx_ext;
			diff_y_s1 <= qy_ext - cy_ext;
			qhl_s1    <= query.query_half_length;
			qhw_s1    <= query.query_half_width;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: absolute differences, always below 2^CW
	// ------------------------------------------------------------------
	logic [CW:0]       neg_x, neg_y;
	logic [CW-1:0]     ax_s2, ay_s2;
	logic [HALF_W-1:0] qhl_s2, qhw_s2;

	assign neg_x = -diff_x_s1;
	assign neg_y = -diff_y_s1;

	always_ff @(posedge clk) begin
		if (rdy2 && vld_s1) begin
			ax_s2  <= diff_x_s1[CW] ? neg_x[CW-1:0] : diff_x_s1[CW-1:0];
			ay_s2  <= diff_y_s1[CW] ? neg_y[CW-1:0] : diff_y_s1[CW-1:0];
			qhl_s2 <= qhl_s1;
			qhw_s2 <= qhw_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: signed gaps per axis and tolerance window tests
	// ------------------------------------------------------------------
	logic [DIST_W-1:0] ax_w, ay_w, hl_w, hw_w, tol_w;
	logic [DIST_W-1:0] dx_s3, dy_s3;
	logic              in_x_s3, in_y_s3, near_x_s3, near_y_s3;

	assign ax_w  = DIST_W'(ax_s2);
	assign ay_w  = DIST_W'(ay_s2);
	assign hl_w  = DIST_W'(box_half_length_q);
	assign hw_w  = DIST_W'(box_half_width_q);
	assign tol_w = DIST_W'(tolerance_q);

	always_ff @(posedge clk) begin
		if (rdy3 && vld_s2) begin
			dx_s3     <= ax_w - DIST_W'(qhl_s2) - hl_w;
			dy_s3     <= ay_w - DIST_W'(qhw_s2) - hw_w;
			// within the slack band of the half extent on each side
			in_x_s3   <= (ax_w <= hl_w + tol_w);
			in_y_s3   <= (ay_w <= hw_w + tol_w);
			near_x_s3 <= (ax_w + tol_w >= hl_w);
			near_y_s3 <= (ay_w + tol_w >= hw_w);
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: pick the direct gap or the root path, square both gaps
	// ------------------------------------------------------------------
	logic              pos_x, pos_y;
	logic [2*CW-1:0]   sq_x_d, sq_y_d;
	logic [2*CW-1:0]   sq_x_s4, sq_y_s4;
	side_t             side_d, side_s4;

	assign pos_x  = !dx_s3[DIST_W-1] && (dx_s3 != '0);
	assign pos_y  = !dy_s3[DIST_W-1] && (dy_s3 != '0);
	assign sq_x_d = dx_s3[CW-1:0] * dx_s3[CW-1:0];
	assign sq_y_d = dy_s3[CW-1:0] * dy_s3[CW-1:0];

	always_comb begin
		side_d.use_root           = pos_x && pos_y;
		side_d.overlap            = !pos_x && !pos_y;
		side_d.center_inside      = in_x_s3 && in_y_s3;
		side_d.center_on_boundary = (near_x_s3 && in_x_s3 && in_y_s3) ||
		                            (near_y_s3 && in_y_s3 && in_x_s3);
		if (pos_x) begin
			side_d.direct_gap = GAP_W'(dx_s3[CW-1:0]);
		end else if (pos_y) begin
			side_d.direct_gap = GAP_W'(dy_s3[CW-1:0]);
		end else begin
			side_d.direct_gap = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && vld_s3) begin
			sq_x_s4 <= sq_x_d;
			sq_y_s4 <= sq_y_d;
			side_s4 <= side_d;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: sum of squares, the radicand
	// ------------------------------------------------------------------
	logic [2*RW-1:0] rad_s5;
	side_t           side_s5;

	always_ff @(posedge clk) begin
		if (rdy5 && vld_s4) begin
			rad_s5  <= {2'b00, sq_x_s4} + {2'b00, sq_y_s4};
			side_s5 <= side_s4;
		end
	end

	// ------------------------------------------------------------------
	// Root pipeline; its last stage is the output register
	// ------------------------------------------------------------------
	logic [RW-1:0] sq_root;
	side_t         out_side;

	aabbqd_isqrt #(
		.RW(RW)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s5),
		.in_ready (sq_in_ready),
		.rad      (rad_s5),
		.in_side  (side_s5),
		.out_valid(result_valid),
		.out_ready(!result_stall),
		.root     (sq_root),
		.out_side (out_side)
	);

	assign result.gap_distance       = out_side.use_root ? GAP_W'(sq_root)
	                                                     : out_side.direct_gap;
	assign result.overlap            = out_side.overlap;
	assign result.center_inside      = out_side.center_inside;
	assign result.center_on_boundary = out_side.center_on_boundary;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// zero gap exactly when the boxes touch or overlap
	`AQD_ASSERT_IMPLIES(a_gap_zero_iff_overlap, result_valid, result.overlap == (result.gap_distance == '0))
	// a center on the edge band is also inside the widened box
	`AQD_ASSERT_IMPLIES(a_edge_implies_inside, result_valid && result.center_on_boundary, result.center_inside)
	// a blocked stage five word stays put
	`AQD_ASSERT_NEXT(a_s5_holds, vld_s5 && !sq_in_ready, vld_s5 && $stable(rad_s5))

endmodule
